/* design/kdd_pkg.sv */
// ----------------------------------------------------------------------------
// kdd_pkg
// Shared types, key codes and lookup functions for the keypad digit entry
// and multiplexed seven-segment display unit.
// ----------------------------------------------------------------------------
package kdd_pkg;

	// Input beat: keypad sample or display tick
	typedef struct packed {
		logic        func;
		logic [15:0] first_scan;
		logic [15:0] confirm_scan;
	} kdd_in_t;

	// Result beat
	typedef struct packed {
		logic [7:0] digit_select;
		logic [6:0] segments;
		logic [3:0] entry_count;
	} kdd_out_t;

	// Function select
	localparam logic FUNC_KEYPAD  = 1'b0;
	localparam logic FUNC_DISPLAY = 1'b1;

	// Key codes (0 means no key)
	localparam logic [4:0] KEY_NONE       = 5'h00;
	localparam logic [4:0] KEY_BASE       = 5'h10;
	localparam logic [4:0] KEY_LAST_DIGIT = 5'h19;
	localparam logic [4:0] KEY_BACKSPACE  = 5'h1A;
	localparam logic [4:0] KEY_CLEAR      = 5'h1D;

	// Stored code shown as a dash
	localparam logic [3:0] DASH_CODE = 4'd10;

	// Enable for position 0; later positions shift right
	localparam logic [7:0] SEL_FIRST = 8'h80;
	localparam int         SEL_LINES = 8;

	// Priority encode a key matrix snapshot, lowest index wins
	function automatic logic [4:0] encode_keys(input logic [15:0] map);
		logic [4:0] code;
		code = KEY_NONE;
		for (int i = 15; i >= 0; i--) begin
			if (map[i]) begin
				code = KEY_BASE | 5'(i);
			end
		end
		return code;
	endfunction

	// Seven-segment pattern, bit0 = segment a
	function automatic logic [6:0] seg_pattern(input logic [3:0] code);
		logic [6:0] pat;
		case (code)
			4'd0:    pat = 7'h3F;
			4'd1:    pat = 7'h06;
			4'd2:    pat = 7'h5B;
			4'd3:    pat = 7'h4F;
			4'd4:    pat = 7'h66;
			4'd5:    pat = 7'h6D;
			4'd6:    pat = 7'h7D;
			4'd7:    pat = 7'h07;
			4'd8:    pat = 7'h7F;
			4'd9:    pat = 7'h6F;
			4'd10:   pat = 7'h40;
			default: pat = 7'h00;
		endcase
		return pat;
	endfunction

endpackage

/* design/keypad_digit_entry_display_unit.sv */
// ----------------------------------------------------------------------------
// keypad_digit_entry_display_unit
// Keypad digit entry with backspace and clear, and a multiplexed
// seven-segment display scanner. One result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------
//  input   | key_valid / key_ready   | key_data (kdd_pkg::kdd_in_t)
//  result  | res_valid / res_ready   | res_data (kdd_pkg::kdd_out_t)
//
//  The path has an input register, then state update and result register.
//  One beat per cycle is sustained while results are taken; the digit store
//  and counters update in the same cycle as the result is registered.
//  Reset returns every digit to dash, the count, last key and scan position
//  to zero. A stalled result holds the pipeline; key_ready drops only when
//  both the input and result registers are full and res_ready is low.
// ----------------------------------------------------------------------------
module keypad_digit_entry_display_unit #(
	parameter int NUM_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_valid,
	output logic              key_ready,
	input  kdd_pkg::kdd_in_t  key_data,
	output logic              res_valid,
	input  logic              res_ready,
	output kdd_pkg::kdd_out_t res_data
);

	localparam int EW = $clog2(NUM_DIGITS + 1);
	localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	// Pipeline registers
	logic              valid_s1;
	kdd_pkg::kdd_in_t  data_s1;
	logic              res_valid_q;
	kdd_pkg::kdd_out_t res_q;

	// Block state
	logic [3:0]    digit_q [NUM_DIGITS];
	logic [EW-1:0] entered_q;
	logic [4:0]    last_key_q;
	logic [PW-1:0] scan_q;

	// Next-state and result logic
	logic              advance;
	logic [4:0]        first_key;
	logic [4:0]        conf_key;
	logic              new_press;
	logic              is_digit;
	logic              do_append;
	logic              do_back;
	logic              do_clear;
	logic [EW-1:0]     entered_d;
	logic [4:0]        last_key_d;
	logic [PW-1:0]     scan_d;
	logic [PW-1:0]     back_idx;
	kdd_pkg::kdd_out_t result;

	assign advance   = !res_valid_q || res_ready;
	assign key_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Key decode for a keypad sample
	assign first_key = kdd_pkg::encode_keys(data_s1.first_scan);
	assign conf_key  = kdd_pkg::encode_keys(data_s1.confirm_scan);
	assign new_press = (last_key_q == kdd_pkg::KEY_NONE) && (first_key != kdd_pkg::KEY_NONE);
	assign is_digit  = (conf_key >= kdd_pkg::KEY_BASE) && (conf_key <= kdd_pkg::KEY_LAST_DIGIT);
	assign do_append = new_press && is_digit && (entered_q < EW'(NUM_DIGITS));
	assign do_back   = new_press && (conf_key == kdd_pkg::KEY_BACKSPACE) && (entered_q != '0);
	assign do_clear  = new_press && (conf_key == kdd_pkg::KEY_CLEAR);
	assign back_idx  = PW'(entered_q - EW'(1));

	always_comb begin
		entered_d = entered_q;
		if (do_clear) begin
			entered_d = '0;
		end else if (do_append) begin
			entered_d = entered_q + EW'(1);
		end else if (do_back) begin
			entered_d = entered_q - EW'(1);
		end
		last_key_d = new_press ? conf_key : first_key;
	end

	// Display scan: show current position, then step to the next, wrapping after the last
	assign scan_d = (scan_q == PW'(NUM_DIGITS - 1)) ? '0 : scan_q + PW'(1);

	always_comb begin
		result = '0;
		if (data_s1.func == kdd_pkg::FUNC_DISPLAY) begin
			if (32'(scan_q) < kdd_pkg::SEL_LINES) begin
				result.digit_select = kdd_pkg::SEL_FIRST >> scan_q;
			end
			result.segments    = kdd_pkg::seg_pattern(digit_q[scan_q]);
			result.entry_count = 4'(entered_q);
		end else begin
			result.entry_count = 4'(entered_d);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_ready) begin
			valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_ready && key_valid) begin
			data_s1 <= key_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= result;
		end
	end

	// State update, one beat per cycle while the result register can advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entered_q  <= '0;
			last_key_q <= kdd_pkg::KEY_NONE;
			scan_q     <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_q[i] <= kdd_pkg::DASH_CODE;
			end
		end else if (advance && valid_s1) begin
			if (data_s1.func == kdd_pkg::FUNC_DISPLAY) begin
				scan_q <= scan_d;
			end else begin
				entered_q  <= entered_d;
				last_key_q <= last_key_d;
				if (do_clear) begin
					for (int i = 0; i < NUM_DIGITS; i++) begin
						digit_q[i] <= kdd_pkg::DASH_CODE;
					end
				end else if (do_append) begin
					digit_q[entered_q[PW-1:0]] <= conf_key[3:0];
				end else if (do_back) begin
					digit_q[back_idx] <= kdd_pkg::DASH_CODE;
				end
			end
		end
	end

	// Checks
	a_entered_range: assert property (@(posedge clk) disable iff (!arst_n)
		entered_q <= EW'(NUM_DIGITS))
		else $error("entry count beyond store depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_q) < NUM_DIGITS)
		else $error("scan position beyond last digit");

	a_entered_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1 && data_s1.func == kdd_pkg::FUNC_KEYPAD) |=> $stable(entered_q))
		else $error("entry count changed without a keypad beat");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1 && data_s1.func == kdd_pkg::FUNC_DISPLAY) |=> $stable(scan_q))
		else $error("scan position moved without a display beat");

	a_select_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $onehot0(res_q.digit_select))
		else $error("more than one digit enabled");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad digit entry and display unit. A queue
// of keypad samples and display ticks feeds a valid/ready driver. Each
// accepted beat runs through a local model of the digit store, the entry
// count, the last key and the scan position. A monitor compares every result
// beat field by field against the oldest predicted result. The run has
// directed cases first, then random press/release sequences with noise under
// four sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_POS     = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_RANDOM  = 192;

	// Segment patterns by stored code, dash at 10, blank above
	localparam logic [6:0] DIGIT_SEGS [16] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              key_valid = 1'b0;
	logic              key_ready;
	kdd_pkg::kdd_in_t  key_data = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	kdd_pkg::kdd_out_t res_data;

	// Stimulus and prediction storage
	kdd_pkg::kdd_in_t  pending_beats [$];
	kdd_pkg::kdd_out_t expected_results [$];

	// Model state
	logic [3:0] shown_digit [NUM_POS];
	logic [3:0] digits_held;
	logic [4:0] held_key;
	int         scan_pos;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int beats_queued = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;
	int n_ticks = 0;
	int n_appends = 0;
	int n_full_drops = 0;
	int n_backspaces = 0;
	int n_clears = 0;

	keypad_digit_entry_display_unit #(
		.NUM_DIGITS(NUM_POS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_valid(key_valid),
		.key_ready(key_ready),
		.key_data (key_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	always #2 clk = ~clk;

	// Lowest set bit of a scan gives the key code, empty scan gives none
	function automatic logic [4:0] scan_code(input logic [15:0] scan);
		logic [4:0] code;
		code = kdd_pkg::KEY_NONE;
		for (int i = 0; i < 16; i++) begin
			if (scan[i] && code == kdd_pkg::KEY_NONE) begin
				code = kdd_pkg::KEY_BASE + 5'(i);
			end
		end
		return code;
	endfunction

	// Advance the entry model by one beat and queue the result it gives
	task automatic predict_result(input kdd_pkg::kdd_in_t beat);
		kdd_pkg::kdd_out_t res;
		logic [4:0]        code;
		res = '0;
		if (beat.func == kdd_pkg::FUNC_KEYPAD) begin
			code = scan_code(beat.first_scan);
			if (held_key == kdd_pkg::KEY_NONE && code != kdd_pkg::KEY_NONE) begin
				code = scan_code(beat.confirm_scan);
				if (code >= kdd_pkg::KEY_BASE && code <= kdd_pkg::KEY_LAST_DIGIT) begin
					if (digits_held < NUM_POS) begin
						shown_digit[digits_held] = 4'(code - kdd_pkg::KEY_BASE);
						digits_held++;
						n_appends++;
					end else begin
						n_full_drops++;
					end
				end else if (code == kdd_pkg::KEY_BACKSPACE) begin
					n_backspaces++;
					if (digits_held > 0) begin
						digits_held--;
						shown_digit[digits_held] = kdd_pkg::DASH_CODE;
					end
				end else if (code == kdd_pkg::KEY_CLEAR) begin
					n_clears++;
					for (int i = 0; i < NUM_POS; i++) begin
						shown_digit[i] = kdd_pkg::DASH_CODE;
					end
					digits_held = '0;
				end
			end
			held_key = code;
		end else begin
			n_ticks++;
			res.digit_select = kdd_pkg::SEL_FIRST >> scan_pos;
			res.segments = DIGIT_SEGS[shown_digit[scan_pos]];
			scan_pos = (scan_pos + 1) % NUM_POS;
		end
		res.entry_count = digits_held;
		expected_results.push_back(res);
	endtask

	task automatic queue_key(input logic [15:0] first, input logic [15:0] confirm);
		kdd_pkg::kdd_in_t beat;
		beat.func = kdd_pkg::FUNC_KEYPAD;
		beat.first_scan = first;
		beat.confirm_scan = confirm;
		pending_beats.push_back(beat);
		beats_queued++;
	endtask

	task automatic queue_tick(input logic [15:0] first, input logic [15:0] confirm);
		kdd_pkg::kdd_in_t beat;
		beat.func = kdd_pkg::FUNC_DISPLAY;
		beat.first_scan = first;
		beat.confirm_scan = confirm;
		pending_beats.push_back(beat);
		beats_queued++;
	endtask

	// Clean press of key k followed by a release
	task automatic queue_press(input int k);
		queue_key(16'h0001 << k, 16'h0001 << k);
		queue_key(16'h0000, 16'(k));
	endtask

	// Random sequences: mostly press/release, some ticks, some noise
	task automatic queue_random(input int n);
		int          r;
		int          k;
		logic [31:0] upper;
		logic [15:0] first;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				queue_tick(16'($urandom), 16'($urandom));
			end else if (r < 85) begin
				r = $urandom_range(99);
				if (r < 70) begin
					k = $urandom_range(9);
				end else if (r < 82) begin
					k = 10;
				end else if (r < 88) begin
					k = 13;
				end else begin
					k = $urandom_range(15);
				end
				// confirm scan: key k plus any keys of higher index
				upper = $urandom & ~((32'h2 << k) - 1);
				first = 16'($urandom);
				if (first == 16'h0000) begin
					first = 16'h8000;
				end
				queue_key(first, 16'((32'h1 << k) | upper));
				// sometimes the key stays down for a while
				if ($urandom_range(3) == 0) begin
					queue_key(16'($urandom) | 16'h0100, 16'($urandom));
				end
				queue_key(16'h0000, 16'($urandom));
			end else begin
				queue_key(16'($urandom), 16'($urandom));
			end
		end
	endtask

	// Hold off until every queued beat is in and every result is out
	task automatic drain_all();
		do begin
			@(posedge clk);
		end while (beats_sent != beats_queued || expected_results.size() != 0);
	endtask

	// Driver: predict on accept, then offer the next beat or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
		end else begin
			if (key_valid && key_ready) begin
				predict_result(key_data);
				beats_sent++;
			end
			if (!key_valid || key_ready) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					key_valid <= 1'b1;
					key_data <= pending_beats.pop_front();
				end else begin
					key_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		kdd_pkg::kdd_out_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result beat: sel=%h seg=%h cnt=%0d",
							res_data.digit_select, res_data.segments, res_data.entry_count);
					end
				end else begin
					want = expected_results.pop_front();
					if (res_data.digit_select !== want.digit_select
							|| res_data.segments !== want.segments
							|| res_data.entry_count !== want.entry_count) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at beat %0d: exp sel=%h seg=%h cnt=%0d",
								results_seen, want.digit_select, want.segments,
								want.entry_count);
							$display("    got sel=%h seg=%h cnt=%0d",
								res_data.digit_select, res_data.segments,
								res_data.entry_count);
						end
					end
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** keypad_digit_entry_display_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_POS; i++) begin
			shown_digit[i] = kdd_pkg::DASH_CODE;
		end
		digits_held = '0;
		held_key = kdd_pkg::KEY_NONE;
		scan_pos = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset display, digits, backspace, unused keys, holds, clear
		queue_tick(16'h0000, 16'h0000);
		queue_press(0);
		queue_key(16'hFFFF, 16'hFE00);
		queue_key(16'h0000, 16'hFFFF);
		queue_tick(16'hFFFF, 16'hFFFF);
		queue_tick(16'h0000, 16'h0000);
		queue_press(10);
		queue_press(10);
		queue_press(10);
		queue_press(11);
		queue_key(16'hFFFF, 16'h8000);
		queue_key(16'h0001, 16'h0001);
		queue_key(16'h0000, 16'h0000);
		queue_key(16'h8000, 16'h0000);
		queue_press(7);
		queue_key(16'h0001, 16'h2000);
		queue_key(16'h0000, 16'h0000);
		queue_tick(16'h0000, 16'h0000);
		drain_all();

		// Fill the store past its depth, then show every position
		for (int i = 0; i < NUM_POS + 2; i++) begin
			queue_press(i % 10);
		end
		for (int i = 0; i < NUM_POS + 1; i++) begin
			queue_tick(16'($urandom), 16'($urandom));
		end
		drain_all();

		// Random phases under different idling
		queue_random(NUM_RANDOM);
		drain_all();

		send_idle_pct = 81;
		recv_stall_pct = 0;
		queue_random(NUM_RANDOM);
		drain_all();

		send_idle_pct = 0;
		recv_stall_pct = 81;
		queue_random(NUM_RANDOM);
		drain_all();

		send_idle_pct = 33;
		recv_stall_pct = 33;
		queue_random(NUM_RANDOM);
		drain_all();

		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors += expected_results.size();
		end

		$display("%0d beats in, %0d results out, %0d display ticks, %0d mismatches",
			beats_sent, results_seen, n_ticks, errors);
		$display("%0d digits entered, %0d dropped when full, %0d backspaces, %0d clears",
			n_appends, n_full_drops, n_backspaces, n_clears);
		if (errors == 0) begin
			$display("** keypad_digit_entry_display_unit: PASSED **");
		end else begin
			$display("** keypad_digit_entry_display_unit: FAILED **");
		end
		$finish;
	end

endmodule
